// ===== sv/cce_pkg.sv =====
// shared constants, types and neighbor offset table for the coface enumerator
package cce_pkg;

  localparam int GRID_W  = 64;
  localparam int GRID_H  = 64;
  localparam int COORD_W = 6;
  localparam int DATA_W  = 32;
  localparam int DEPTH   = GRID_W * GRID_H;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int NCOF    = 4;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    DIM_VERTEX = 2'd0,
    DIM_EDGE   = 2'd1,
    DIM_SQUARE = 2'd2,
    DIM_NONE   = 2'd3
  } dim_e;

  typedef enum logic {
    KIND_HORIZ = 1'b0,
    KIND_VERT  = 1'b1
  } kind_e;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } off_t;

  // one finished query, handed from the read pipeline to the result sequencer
  typedef struct packed {
    logic                              valid;
    logic [NCOF-1:0]                   keep;
    logic [NCOF-1:0][DATA_W-1:0]       birth;
    logic [NCOF-1:0][COORD_W-1:0]      cx;
    logic [NCOF-1:0][COORD_W-1:0]      cy;
    logic [NCOF-1:0]                   ck;
    logic [1:0]                        dim;
  } batch_t;

  // pixel read by each of the four read slots of a query
  function automatic off_t slot_offset(logic [1:0] dim, logic kind, logic [1:0] slot);
    off_t o;
    o.dx = 2'sd0;
    o.dy = 2'sd0;
    if (dim == DIM_VERTEX) begin
      case (slot)
        2'd0: o.dy = 2'sd1;
        2'd1: o.dy = -2'sd1;
        2'd2: o.dx = 2'sd1;
        default: o.dx = -2'sd1;
      endcase
    end else if (kind == KIND_HORIZ) begin
      o.dx = slot[0] ? 2'sd1 : 2'sd0;
      o.dy = slot[1] ? -2'sd1 : 2'sd1;
    end else begin
      o.dx = slot[1] ? -2'sd1 : 2'sd1;
      o.dy = slot[0] ? 2'sd1 : 2'sd0;
    end
    return o;
  endfunction

endpackage

// ===== sv/cce_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module cce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/cce_reader.sv =====
// query read pipeline: issues four grid reads per query and folds them into coface births
module cce_reader (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [cce_pkg::COORD_W-1:0]      x_i,
  input  logic [cce_pkg::COORD_W-1:0]      y_i,
  input  logic                             kind_i,
  input  logic [1:0]                       dim_i,
  input  logic signed [cce_pkg::DATA_W-1:0] val_i,
  input  logic signed [cce_pkg::DATA_W-1:0] thresh_i,
  output logic                             busy_o,
  output logic [cce_pkg::ADDR_W-1:0]       raddr_o,
  input  logic [cce_pkg::DATA_W-1:0]       rdata_i,
  output cce_pkg::batch_t                  batch_o
);

  localparam int CW = cce_pkg::COORD_W;
  localparam int DW = cce_pkg::DATA_W;

  // issue stage
  logic          active_q;
  logic [1:0]    slot_q;
  logic [CW-1:0] qx_q, qy_q;
  logic          qkind_q;
  logic [1:0]    qdim_q;
  logic [DW-1:0] qval_q;

  // data stage
  logic          rd_valid_q;
  logic [1:0]    rd_slot_q;
  logic          rd_oob_q;
  logic [CW-1:0] mx_q, my_q;
  logic          mkind_q;
  logic [1:0]    mdim_q;
  logic [DW-1:0] mval_q;
  logic [cce_pkg::NCOF-1:0][DW-1:0] acc_q, acc_d;

  cce_pkg::off_t   off;
  logic signed [7:0] nx, ny;
  logic            oob;

  assign busy_o = active_q && (slot_q != 2'd3);

  always_comb begin
    off = cce_pkg::slot_offset(qdim_q, qkind_q, slot_q);
    nx  = $signed({2'b00, qx_q}) + 8'(off.dx);
    ny  = $signed({2'b00, qy_q}) + 8'(off.dy);
    oob = (nx < 0) || (ny < 0) || (int'(nx) >= cce_pkg::GRID_W) ||
          (int'(ny) >= cce_pkg::GRID_H);
    raddr_o = cce_pkg::ADDR_W'(int'(ny[CW-1:0]) * cce_pkg::GRID_W + int'(nx[CW-1:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      slot_q     <= 2'd0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= active_q;
      if (accept_i) begin
        active_q <= 1'b1;
        slot_q   <= 2'd0;
      end else if (active_q) begin
        slot_q <= slot_q + 2'd1;
        if (slot_q == 2'd3) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      qx_q    <= x_i;
      qy_q    <= y_i;
      qkind_q <= kind_i;
      qdim_q  <= dim_i;
      qval_q  <= val_i;
    end
    rd_slot_q <= slot_q;
    rd_oob_q  <= oob;
    if (active_q && slot_q == 2'd0) begin
      mx_q    <= qx_q;
      my_q    <= qy_q;
      mkind_q <= qkind_q;
      mdim_q  <= qdim_q;
      mval_q  <= qval_q;
    end
    acc_q <= acc_d;
  end

  // fold the arriving pixel into its coface birth
  logic                 vertex;
  logic [1:0]           idx;
  logic                 first;
  logic signed [DW-1:0] pixel, base;

  always_comb begin
    vertex = (mdim_q == cce_pkg::DIM_VERTEX);
    idx    = vertex ? rd_slot_q : {1'b0, rd_slot_q[1]};
    first  = vertex || !rd_slot_q[0];
    pixel  = rd_oob_q ? thresh_i : $signed(rdata_i);
    base   = first ? $signed(mval_q) : $signed(acc_q[idx]);
    acc_d  = acc_q;
    if (rd_valid_q) begin
      acc_d[idx] = (pixel > base) ? pixel : base;
    end
  end

  // hand the finished query over when its last read is folded in
  always_comb begin
    batch_o.valid = rd_valid_q && (rd_slot_q == 2'd3);
    batch_o.birth = acc_d;
    batch_o.dim   = 2'd0;
    batch_o.cx    = '0;
    batch_o.cy    = '0;
    batch_o.ck    = '0;
    batch_o.keep  = '0;
    for (int i = 0; i < cce_pkg::NCOF; i++) begin
      batch_o.keep[i] = ($signed(acc_d[i]) != thresh_i);
    end
    unique case (mdim_q)
      cce_pkg::DIM_VERTEX: begin
        batch_o.dim = cce_pkg::DIM_EDGE;
        batch_o.cx  = {mx_q - CW'(1), mx_q, mx_q, mx_q};
        batch_o.cy  = {my_q, my_q, my_q - CW'(1), my_q};
        batch_o.ck  = {cce_pkg::KIND_HORIZ, cce_pkg::KIND_HORIZ,
                       cce_pkg::KIND_VERT, cce_pkg::KIND_VERT};
      end
      cce_pkg::DIM_EDGE: begin
        batch_o.dim     = cce_pkg::DIM_SQUARE;
        batch_o.keep[3:2] = 2'b00;
        if (mkind_q == cce_pkg::KIND_HORIZ) begin
          batch_o.cx = {CW'(0), CW'(0), mx_q, mx_q};
          batch_o.cy = {CW'(0), CW'(0), my_q - CW'(1), my_q};
        end else begin
          batch_o.cx = {CW'(0), CW'(0), mx_q - CW'(1), mx_q};
          batch_o.cy = {CW'(0), CW'(0), my_q, my_q};
        end
      end
      default: begin
        batch_o.keep = '0;
      end
    endcase
  end

endmodule

// ===== sv/cce_emitter.sv =====
// result sequencer: plays out the kept cofaces of one query, one per cycle
module cce_emitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cce_pkg::batch_t              batch_i,
  output logic                         valid_o,
  output logic                         has_coface_o,
  output logic [cce_pkg::COORD_W-1:0]  x_o,
  output logic [cce_pkg::COORD_W-1:0]  y_o,
  output logic                         kind_o,
  output logic [1:0]                   dim_o,
  output logic [cce_pkg::DATA_W-1:0]   birth_o,
  output logic                         last_o
);

  localparam int N = cce_pkg::NCOF;

  logic [N-1:0]    pend_q, pend_d;
  logic            empty_q;
  cce_pkg::batch_t b_q;
  logic [1:0]      sel;

  always_comb begin
    sel = 2'd0;
    for (int i = N - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = 2'(i);
      end
    end
    pend_d      = pend_q;
    pend_d[sel] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      empty_q <= 1'b0;
    end else if (batch_i.valid) begin
      pend_q  <= batch_i.keep;
      empty_q <= (batch_i.keep == '0);
    end else begin
      pend_q  <= pend_d;
      empty_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_i.valid) begin
      b_q <= batch_i;
    end
  end

  always_comb begin
    valid_o      = empty_q || (pend_q != '0);
    has_coface_o = !empty_q;
    x_o          = empty_q ? '0 : b_q.cx[sel];
    y_o          = empty_q ? '0 : b_q.cy[sel];
    kind_o       = empty_q ? 1'b0 : b_q.ck[sel];
    dim_o        = empty_q ? 2'd0 : b_q.dim;
    birth_o      = empty_q ? '0 : b_q.birth[sel];
    last_o       = empty_q || (pend_d == '0);
  end

endmodule

// ===== sv/cubical_coface_enumerator.sv =====
// top level: coboundary enumerator for cells of a 2d cubical complex over a pixel grid
// a query's reads pass the issue stage, the grid ram read register and the data stage, and
// its first result is registered in the result sequencer; the rest follow one per cycle
// a new query can be accepted during the last of the previous query's four grid ram reads
// a write transaction may follow directly whenever busy is low
// reset clears the control state and sets threshold to 0x7fffffff
// the grid ram is not cleared: entries are undefined until written; results cannot stall
module cubical_coface_enumerator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              func_i,
  input  logic [cce_pkg::COORD_W-1:0]       cell_x_i,
  input  logic [cce_pkg::COORD_W-1:0]       cell_y_i,
  input  logic                              cell_kind_i,
  input  logic [1:0]                        cell_dim_i,
  input  logic signed [cce_pkg::DATA_W-1:0] value_i,
  // threshold register write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic signed [cce_pkg::DATA_W-1:0] cfg_data_i,
  // result strobe and payload
  output logic                              out_valid_o,
  output logic                              has_coface_o,
  output logic [cce_pkg::COORD_W-1:0]       coface_x_o,
  output logic [cce_pkg::COORD_W-1:0]       coface_y_o,
  output logic                              coface_kind_o,
  output logic [1:0]                        coface_dim_o,
  output logic signed [cce_pkg::DATA_W-1:0] coface_birth_o,
  output logic                              last_o
);

  logic signed [cce_pkg::DATA_W-1:0] threshold_q;

  logic                        accept;
  logic                        query_acc;
  logic                        write_acc;
  logic                        wr_in_grid;
  logic [cce_pkg::ADDR_W-1:0]  waddr;
  logic [cce_pkg::ADDR_W-1:0]  raddr;
  logic [cce_pkg::DATA_W-1:0]  rdata;
  logic [cce_pkg::DATA_W-1:0]  birth;
  cce_pkg::batch_t             batch;

  // the threshold register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 32'sh7fffffff;
    end else if (cfg_valid_i && cfg_ready_o) begin
      threshold_q <= cfg_data_i;
    end
  end

  // transaction decode
  assign accept     = start && !busy;
  assign query_acc  = accept && (func_i == cce_pkg::FUNC_QUERY);
  assign write_acc  = accept && (func_i == cce_pkg::FUNC_WRITE);
  // writes outside the grid are dropped
  assign wr_in_grid = (int'(cell_x_i) < cce_pkg::GRID_W) && (int'(cell_y_i) < cce_pkg::GRID_H);
  assign waddr      = cce_pkg::ADDR_W'(int'(cell_y_i) * cce_pkg::GRID_W + int'(cell_x_i));

  // grid store: write straight from the command port, read by the query pipeline;
  // a write taken on the edge of a query's final read does not disturb that read
  cce_ram #(
    .WIDTH (cce_pkg::DATA_W),
    .DEPTH (cce_pkg::DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (write_acc && wr_in_grid),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // busy drops in the cycle of a query's last read so the next one overlaps
  cce_reader u_reader (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (query_acc),
    .x_i      (cell_x_i),
    .y_i      (cell_y_i),
    .kind_i   (cell_kind_i),
    .dim_i    (cell_dim_i),
    .val_i    (value_i),
    .thresh_i (threshold_q),
    .busy_o   (busy),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .batch_o  (batch)
  );

  // a query yields at most four results, so the sequencer is free before the next batch
  cce_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .batch_i      (batch),
    .valid_o      (out_valid_o),
    .has_coface_o (has_coface_o),
    .x_o          (coface_x_o),
    .y_o          (coface_y_o),
    .kind_o       (coface_kind_o),
    .dim_o        (coface_dim_o),
    .birth_o      (birth),
    .last_o       (last_o)
  );

  assign coface_birth_o = $signed(birth);

endmodule
